// ===== hw/rtl/rgbhsl_pkg.sv =====
`timescale 1ns / 1ps
// rgbhsl_pkg: constants, divider word type and divider step for the RGB to HSL converter.
// Self-contained; imported by rgb_to_hsl_converter.

package rgbhsl_pkg;

	localparam int HUE_FRAC_BITS = 6;
	localparam int HUE_W         = 15;
	localparam int HUE_SCALE     = 60 << HUE_FRAC_BITS;
	localparam int HQ_W          = $clog2(HUE_SCALE + 1);
	localparam int HN_W          = 8 + HQ_W;
	localparam int HS_W          = HQ_W + 3;
	localparam int HX_W          = (HS_W > HUE_W) ? HS_W : HUE_W;

	localparam int SQ_W          = 8;
	localparam int SN_W          = 16;
	localparam int SAT_MAX       = 255;
	localparam int SAT_SPAN      = 510;

	localparam int LUMA_R        = 299;
	localparam int LUMA_G        = 587;
	localparam int LUMA_B        = 114;
	localparam int LUMA_W        = 18;
	// 2560 = 512 * 5; divide by 5 through a reciprocal on the 9-bit quotient
	localparam int LUMA_SHIFT    = 9;
	localparam int LIT_X_W       = LUMA_W - LUMA_SHIFT;
	localparam int LIT_RECIP     = 205;
	localparam int LIT_RSH       = 10;
	localparam int LIT_P_W       = LIT_X_W + 8;
	localparam int LIT_W         = 7;
	localparam int LIT_MAX       = 99;

	localparam int DIV_STEPS     = 2;
	localparam int DIV_BITS      = (HQ_W > SQ_W) ? HQ_W : SQ_W;
	localparam int DIV_STAGES    = (DIV_BITS + DIV_STEPS - 1) / DIV_STEPS;

	typedef struct packed {
		logic            grey;
		logic [2:0]      sector;
		logic            sub;
		logic [LIT_W-1:0] lit;
		logic [7:0]      dvs;
		logic [7:0]      hrem;
		logic [HQ_W-1:0] hquo;
		logic [8:0]      sden;
		logic [8:0]      srem;
		logic [SQ_W-1:0] squo;
	} div_t;

	// one restoring step of the hue and saturation dividers
	function automatic div_t div_step(div_t x, logic do_h, logic do_s);
		div_t       y;
		logic [8:0] ht;
		logic [9:0] st;
		y  = x;
		ht = {x.hrem, x.hquo[HQ_W-1]};
		st = {x.srem, x.squo[SQ_W-1]};
		if (do_h) begin
			if (ht >= {1'b0, x.dvs}) begin
				y.hrem = 8'(ht - {1'b0, x.dvs});
				y.hquo = {x.hquo[HQ_W-2:0], 1'b1};
			end else begin
				y.hrem = ht[7:0];
				y.hquo = {x.hquo[HQ_W-2:0], 1'b0};
			end
		end
		if (do_s) begin
			if (st >= {1'b0, x.sden}) begin
				y.srem = 9'(st - {1'b0, x.sden});
				y.squo = {x.squo[SQ_W-2:0], 1'b1};
			end else begin
				y.srem = st[8:0];
				y.squo = {x.squo[SQ_W-2:0], 1'b0};
			end
		end
		return y;
	endfunction

endpackage

// ===== hw/rtl/rgb_to_hsl_converter.sv =====
`timescale 1ns / 1ps
// rgb_to_hsl_converter: pipelined RGB to HSL pixel converter.
// Depends on rgbhsl_pkg for constants, the divider word and the divider step.

// Converts one 8-bit RGB pixel per clock into hue (1/64 degree units), HSL
// saturation (0..255), luma lightness (0..99) and a grey flag. The pipeline
// holds a min/max and luma stage, a numerator stage, the restoring divider
// stages that produce two quotient bits each for the hue fraction and the
// saturation in parallel, and the output register. A new pixel is accepted
// every cycle; a stall on the result side fills the bubbles first, then
// backs up to pix_ready.

module rgb_to_hsl_converter
	import rgbhsl_pkg::*;
(
	input  logic             clk,
	input  logic             arst_n,
	input  logic             pix_valid,
	output logic             pix_ready,
	input  logic [7:0]       red,
	input  logic [7:0]       green,
	input  logic [7:0]       blue,
	output logic             hsl_valid,
	input  logic             hsl_ready,
	output logic [HUE_W-1:0] hue,
	output logic [7:0]       saturation,
	output logic [LIT_W-1:0] lightness,
	output logic             grey
);

	logic              vld_s1, vld_s2;
	logic              grey_s1, sub_s1;
	logic [2:0]        sector_s1;
	logic [7:0]        num_s1, d_s1;
	logic [8:0]        lsum_s1;
	logic [LUMA_W-1:0] luma_s1;
	div_t              p_s2;
	logic              dv_vld_s3 [DIV_STAGES];
	div_t              dv_s3 [DIV_STAGES];
	div_t              dv_nxt [DIV_STAGES];

	logic              adv_s1, adv_s2, adv_o;
	logic              adv_dv [DIV_STAGES];

	logic [7:0]        mx, mn;
	logic              grey_c, sub_c;
	logic [2:0]        sector_c;
	logic [7:0]        num_c;
	logic [LUMA_W-1:0] luma_c;

	logic [HN_W-1:0]    hnum;
	logic [SN_W-1:0]    snum;
	logic [LIT_X_W-1:0] lit_x;
	logic [LIT_P_W-1:0] lit_p;
	div_t               p_c;

	div_t              last;
	logic [HX_W-1:0]   hbase, hx;
	logic [HQ_W:0]     hq_up;

	// handshake: a stage loads when empty or when its successor loads
	always_comb begin
		adv_o = !hsl_valid || hsl_ready;
		for (int k = DIV_STAGES - 1; k >= 0; k--) begin
			if (k == DIV_STAGES - 1) begin
				adv_dv[k] = !dv_vld_s3[k] || adv_o;
			end else begin
				adv_dv[k] = !dv_vld_s3[k] || adv_dv[k+1];
			end
		end
		adv_s2 = !vld_s2 || adv_dv[0];
		adv_s1 = !vld_s1 || adv_s2;
	end

	assign pix_ready = adv_s1;

	// stage 1: ordering, sector and luma
	always_comb begin
		mx = red;
		mn = red;
		if (green > mx) mx = green;
		if (blue > mx)  mx = blue;
		if (green < mn) mn = green;
		if (blue < mn)  mn = blue;
		grey_c = (red == green) && (green == blue);
		if (red >= blue) begin
			if (green > red) begin
				sector_c = 3'd2; sub_c = 1'b1; num_c = red - blue;
			end else if (green >= blue) begin
				sector_c = 3'd0; sub_c = 1'b0; num_c = green - blue;
			end else begin
				sector_c = 3'd6; sub_c = 1'b1; num_c = blue - green;
			end
		end else begin
			if (green >= blue) begin
				sector_c = 3'd2; sub_c = 1'b0; num_c = blue - red;
			end else if (green > red) begin
				sector_c = 3'd4; sub_c = 1'b1; num_c = green - red;
			end else begin
				sector_c = 3'd4; sub_c = 1'b0; num_c = red - green;
			end
		end
		luma_c = LUMA_W'(red) * LUMA_W'(LUMA_R) + LUMA_W'(green) * LUMA_W'(LUMA_G)
			+ LUMA_W'(blue) * LUMA_W'(LUMA_B);
	end

	always_ff @(posedge clk) begin
		if (adv_s1) begin
			grey_s1   <= grey_c;
			sector_s1 <= sector_c;
			sub_s1    <= sub_c;
			num_s1    <= num_c;
			d_s1      <= mx - mn;
			lsum_s1   <= 9'(mx) + 9'(mn);
			luma_s1   <= luma_c;
		end
	end

	// stage 2: dividends, divisors and lightness
	always_comb begin
		hnum  = HN_W'(num_s1) * HN_W'(HUE_SCALE);
		snum  = SN_W'(d_s1) * SN_W'(SAT_MAX);
		lit_x = luma_s1[LUMA_W-1:LUMA_SHIFT];
		lit_p = LIT_P_W'(lit_x) * LIT_P_W'(LIT_RECIP);
		p_c.grey   = grey_s1;
		p_c.sector = sector_s1;
		p_c.sub    = sub_s1;
		p_c.lit    = lit_p[LIT_RSH+LIT_W-1:LIT_RSH];
		p_c.dvs    = d_s1;
		p_c.hrem   = hnum[HN_W-1:HQ_W];
		p_c.hquo   = hnum[HQ_W-1:0];
		p_c.sden   = lsum_s1[8] ? 9'(SAT_SPAN) - lsum_s1 : lsum_s1;
		p_c.srem   = {1'b0, snum[SN_W-1:SQ_W]};
		p_c.squo   = snum[SQ_W-1:0];
	end

	always_ff @(posedge clk) begin
		if (adv_s2) begin
			p_s2 <= p_c;
		end
	end

	// divider stages: DIV_STEPS quotient bits each
	always_comb begin
		div_t cur;
		for (int k = 0; k < DIV_STAGES; k++) begin
			if (k == 0) begin
				cur = p_s2;
			end else begin
				cur = dv_s3[k-1];
			end
			for (int j = 0; j < DIV_STEPS; j++) begin
				cur = div_step(cur, (k * DIV_STEPS + j) < HQ_W, (k * DIV_STEPS + j) < SQ_W);
			end
			dv_nxt[k] = cur;
		end
	end

	always_ff @(posedge clk) begin
		for (int k = 0; k < DIV_STAGES; k++) begin
			if (adv_dv[k]) begin
				dv_s3[k] <= dv_nxt[k];
			end
		end
	end

	// output: zero for grey, else sector base plus or minus the fraction, ceiling when subtracting
	always_comb begin
		last  = dv_s3[DIV_STAGES-1];
		hbase = HX_W'(last.sector) * HX_W'(HUE_SCALE);
		hq_up = {1'b0, last.hquo} + {{HQ_W{1'b0}}, (last.hrem != 8'd0)};
		if (last.grey) begin
			hx = '0;
		end else if (last.sub) begin
			hx = hbase - HX_W'(hq_up);
		end else begin
			hx = hbase + HX_W'(last.hquo);
		end
	end

	always_ff @(posedge clk) begin
		if (adv_o) begin
			hue        <= hx[HUE_W-1:0];
			saturation <= last.grey ? 8'd0 : last.squo;
			lightness  <= last.lit;
			grey       <= last.grey;
		end
	end

	// valid bits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1    <= 1'b0;
			vld_s2    <= 1'b0;
			hsl_valid <= 1'b0;
			for (int k = 0; k < DIV_STAGES; k++) begin
				dv_vld_s3[k] <= 1'b0;
			end
		end else begin
			if (adv_s1) vld_s1 <= pix_valid;
			if (adv_s2) vld_s2 <= vld_s1;
			for (int k = 0; k < DIV_STAGES; k++) begin
				if (adv_dv[k]) begin
					if (k == 0) begin
						dv_vld_s3[k] <= vld_s2;
					end else begin
						dv_vld_s3[k] <= dv_vld_s3[k-1];
					end
				end
			end
			if (adv_o) hsl_valid <= dv_vld_s3[DIV_STAGES-1];
		end
	end

	a_grey_zero: assert property (@(posedge clk) disable iff (!arst_n)
		hsl_valid && grey |-> hue == '0 && saturation == 8'd0)
		else $error("grey word with nonzero hue or saturation");

	a_color_sat: assert property (@(posedge clk) disable iff (!arst_n)
		hsl_valid && !grey |-> saturation != 8'd0)
		else $error("colored word with zero saturation");

	a_lit_range: assert property (@(posedge clk) disable iff (!arst_n)
		hsl_valid |-> lightness <= LIT_W'(LIT_MAX))
		else $error("lightness out of range");

endmodule
